// ----- design/rers_pkg.sv -----
package rers_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int COLOR_BITS     = 8;
  localparam int N_SPAN         = 7;
  localparam int SEL_BITS       = $clog2(N_SPAN);

endpackage

// ----- design/rers_emit.sv -----
module rers_emit
  import rers_pkg::*;
#(
  parameter int SB = COORD_BITS_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ld_valid,
  output logic                  ld_ready,
  input  logic [N_SPAN-1:0]     ld_mask,
  input  logic [SB-1:0]         ld_y,
  input  logic [SB-1:0]         ld_x     [N_SPAN],
  input  logic [SB-1:0]         ld_len   [N_SPAN],
  input  logic [COLOR_BITS-1:0] ld_color [N_SPAN],
  output logic                  span_valid,
  input  logic                  span_ready,
  output logic [SB-1:0]         span_x,
  output logic [SB-1:0]         span_y,
  output logic [SB-1:0]         span_length,
  output logic [COLOR_BITS-1:0] span_color,
  output logic                  span_last
);

  logic [N_SPAN-1:0]     pend_r, pend_nxt;
  logic [SB-1:0]         cy_r;
  logic [SB-1:0]         cx_r [N_SPAN];
  logic [SB-1:0]         cl_r [N_SPAN];
  logic [COLOR_BITS-1:0] cc_r [N_SPAN];

  logic                  ov_r, ov_nxt;
  logic [SB-1:0]         ox_r, oy_r, ol_r;
  logic [COLOR_BITS-1:0] oc_r;
  logic                  olast_r;

  logic                  can_out, emit, load;
  logic                  found;
  logic [SEL_BITS-1:0]   sel;
  logic [N_SPAN-1:0]     rest;

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < N_SPAN; i++) begin
      if (!found && pend_r[i]) begin
        found = 1'b1;
        sel   = SEL_BITS'(i);
      end
    end
    rest = pend_r & ~(N_SPAN'(1) << sel);
  end

  assign can_out  = !ov_r || span_ready;
  assign emit     = (pend_r != '0) && can_out;
  assign ld_ready = (pend_r == '0) || (emit && (rest == '0));
  assign load     = ld_valid && ld_ready;

  always_comb begin
    if (load) begin
      pend_nxt = ld_mask;
    end else if (emit) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (span_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cy_r <= ld_y;
      for (int i = 0; i < N_SPAN; i++) begin
        cx_r[i] <= ld_x[i];
        cl_r[i] <= ld_len[i];
        cc_r[i] <= ld_color[i];
      end
    end
    if (emit) begin
      ox_r    <= cx_r[sel];
      oy_r    <= cy_r;
      ol_r    <= cl_r[sel];
      oc_r    <= cc_r[sel];
      olast_r <= (rest == '0);
    end
  end

  assign span_valid  = ov_r;
  assign span_x      = ox_r;
  assign span_y      = oy_r;
  assign span_length = ol_r;
  assign span_color  = oc_r;
  assign span_last   = olast_r;

endmodule

// ----- design/rounded_emboss_row_spans.sv -----
// Embossed rounded-rectangle row rasterizer. Each input item is one row request; the block
// returns that row's spans (body, arc fills, highlight edge and pixel, shadow edge and pixel)
// in painting order, one span per output item, with tlast on the final span of the row. A row
// outside the height, or one whose spans are all empty, yields no output item. Items enter a
// seven-stage pipeline (radius clamp, arc geometry, one multiply, then a floor square root
// resolving two root bits per stage) and may be presented every cycle unless out_tready
// backs up the pipeline; a row reaches its first span through the stage registers, then the
// serializer's span store and output register. The serializer is the rate limit: a row holds
// it until its last span (at most six) is issued, and the next row may load as that span goes.
module rounded_emboss_row_spans
  import rers_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int SB        = COORD_BITS + 1,
  localparam int OFF_Y     = COORD_BITS,
  localparam int OFF_W     = 2 * COORD_BITS,
  localparam int OFF_H     = OFF_W + SB,
  localparam int OFF_R     = OFF_H + SB,
  localparam int OFF_F     = OFF_R + COORD_BITS,
  localparam int OFF_HI    = OFF_F + COLOR_BITS,
  localparam int OFF_SH    = OFF_HI + COLOR_BITS,
  localparam int OFF_ROW   = OFF_SH + COLOR_BITS,
  localparam int IN_BITS   = OFF_ROW + COORD_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 3 * SB + COLOR_BITS,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // left_x, top_y, width, height, radius, fill_color, highlight_color, shadow_color, row
  input  logic [IN_W-1:0]  in_tdata,
  // command
  input  logic [0:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // span_x, span_y, span_length, color
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int CB        = COORD_BITS;
  localparam int PROD_BITS = CB + SB;
  localparam int ARG_BITS  = 16;
  localparam int ROOT_BITS = 8;
  localparam int SQRT_CAP  = 46340;
  localparam int NST       = 7;
  localparam int SQ_FIRST  = 3;

  typedef struct packed {
    logic                  cmd;
    logic [CB-1:0]         x;
    logic [SB-1:0]         w;
    logic [SB-1:0]         h;
    logic [CB-1:0]         r;
    logic [CB-1:0]         yo;
    logic [SB-1:0]         sy;
    logic [COLOR_BITS-1:0] fill;
    logic [COLOR_BITS-1:0] hi;
    logic [COLOR_BITS-1:0] sh;
    logic                  ok;
    logic                  top;
    logic                  bot;
    logic                  arc;
    logic [SB-1:0]         inner;
    logic [CB-1:0]         fa;
    logic [SB-1:0]         fb;
    logic [PROD_BITS-1:0]  prod;
    logic [ARG_BITS-1:0]   arg;
    logic [ROOT_BITS-1:0]  root;
  } item_t;

  function automatic logic [ROOT_BITS-1:0] sqrt_two(input logic [ROOT_BITS-1:0] root,
                                                     input logic [ARG_BITS-1:0]  arg,
                                                     input int                   hb);
    logic [ROOT_BITS-1:0] rt;
    logic [ROOT_BITS-1:0] t;
    rt = root;
    for (int k = 0; k < 2; k++) begin
      t = rt | (ROOT_BITS'(1) << (hb - k));
      if (ARG_BITS'(t) * ARG_BITS'(t) <= arg) begin
        rt = t;
      end
    end
    return rt;
  endfunction

  item_t          stg_r   [NST];
  item_t          stg_nxt [NST];
  logic [NST-1:0] vld_r;
  logic [NST:0]   adv;

  logic                  em_ready;
  logic [N_SPAN-1:0]     c_mask;
  logic [SB-1:0]         c_x     [N_SPAN];
  logic [SB-1:0]         c_len   [N_SPAN];
  logic [COLOR_BITS-1:0] c_color [N_SPAN];

  logic [SB-1:0]         sp_x, sp_y, sp_len;
  logic [COLOR_BITS-1:0] sp_color;

  // stall chain: a stage loads when it is empty or the one after it moves
  always_comb begin
    adv[NST] = em_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end
  assign in_tready = adv[0];

  // stage 0: unpack, clamp radius, row flags
  always_comb begin
    item_t         s;
    logic [CB-1:0] rc;
    s       = '0;
    s.cmd   = in_tuser[0];
    s.x     = in_tdata[0 +: CB];
    s.w     = in_tdata[OFF_W +: SB];
    s.h     = in_tdata[OFF_H +: SB];
    s.fill  = in_tdata[OFF_F +: COLOR_BITS];
    s.hi    = in_tdata[OFF_HI +: COLOR_BITS];
    s.sh    = in_tdata[OFF_SH +: COLOR_BITS];
    s.yo    = in_tdata[OFF_ROW +: CB];
    rc      = in_tdata[OFF_R +: CB];
    if (rc > s.w[SB-1:1]) begin
      rc = s.w[SB-1:1];
    end
    if (rc > s.h[SB-1:1]) begin
      rc = s.h[SB-1:1];
    end
    s.r     = rc;
    s.sy    = SB'(in_tdata[OFF_Y +: CB]) + SB'(s.yo);
    s.ok    = SB'(s.yo) < s.h;
    s.top   = (s.yo == '0);
    s.bot   = (SB'(s.yo) == s.h - SB'(1));
    stg_nxt[0] = s;
  end

  // stage 1: arc rows, factors of r*r - dy*dy, inner band width
  always_comb begin
    item_t         s;
    logic [SB-1:0] hmr;
    logic [CB-1:0] dy;
    logic          arc_t, arc_b;
    s       = stg_r[0];
    hmr     = s.h - SB'(s.r);
    arc_t   = s.yo < s.r;
    arc_b   = SB'(s.yo) >= hmr;
    if (arc_t) begin
      dy = s.r - s.yo;
    end else if (arc_b) begin
      dy = CB'(SB'(s.yo) - hmr);
    end else begin
      dy = s.r;
    end
    s.arc   = arc_t || arc_b;
    s.fa    = s.r - dy;
    s.fb    = SB'(s.r) + SB'(dy);
    s.inner = s.w - {s.r, 1'b0};
    stg_nxt[1] = s;
  end

  // stage 2: (r - dy) * (r + dy)
  always_comb begin
    item_t s;
    s      = stg_r[1];
    s.prod = PROD_BITS'(s.fa) * PROD_BITS'(s.fb);
    stg_nxt[2] = s;
  end

  // stages 3..6: capped argument, then two root bits per stage
  for (genvar g = SQ_FIRST; g < NST; g++) begin : g_sqrt
    always_comb begin
      item_t s;
      s = stg_r[g-1];
      if (g == SQ_FIRST) begin
        s.arg  = (s.prod > PROD_BITS'(SQRT_CAP)) ? ARG_BITS'(SQRT_CAP)
                                                  : s.prod[ARG_BITS-1:0];
        s.root = '0;
      end
      s.root = sqrt_two(s.root, s.arg, ROOT_BITS - 1 - 2 * (g - SQ_FIRST));
      stg_nxt[g] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // span list in painting order
  always_comb begin
    item_t         s;
    logic [SB-1:0] xe, re, dx, xr;
    logic          fill_en;
    s       = stg_r[NST-1];
    xe      = SB'(s.x);
    re      = SB'(s.r);
    dx      = SB'(s.root);
    xr      = xe + re;
    fill_en = s.ok && !s.cmd;

    c_mask[0]  = fill_en && (s.arc ? (s.inner != '0) : (s.w != '0));
    c_x[0]     = s.arc ? xr : xe;
    c_len[0]   = s.arc ? s.inner : s.w;
    c_color[0] = s.fill;

    c_mask[1]  = fill_en && s.arc && (s.root != '0);
    c_x[1]     = xr - dx;
    c_len[1]   = dx;
    c_color[1] = s.fill;

    c_mask[2]  = c_mask[1];
    c_x[2]     = xe + s.w - re;
    c_len[2]   = dx;
    c_color[2] = s.fill;

    c_mask[3]  = s.ok && s.top && (s.inner != '0);
    c_x[3]     = xr;
    c_len[3]   = s.inner;
    c_color[3] = s.hi;

    c_mask[4]  = s.ok && s.arc;
    c_x[4]     = xr - dx;
    c_len[4]   = SB'(1);
    c_color[4] = s.hi;

    c_mask[5]  = s.ok && s.bot && (s.inner != '0);
    c_x[5]     = xr;
    c_len[5]   = s.inner;
    c_color[5] = s.sh;

    c_mask[6]  = s.ok && s.arc;
    c_x[6]     = xe + s.w - SB'(1) - re + dx;
    c_len[6]   = SB'(1);
    c_color[6] = s.sh;
  end

  rers_emit #(
    .SB (SB)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld_valid    (vld_r[NST-1]),
    .ld_ready    (em_ready),
    .ld_mask     (c_mask),
    .ld_y        (stg_r[NST-1].sy),
    .ld_x        (c_x),
    .ld_len      (c_len),
    .ld_color    (c_color),
    .span_valid  (out_tvalid),
    .span_ready  (out_tready),
    .span_x      (sp_x),
    .span_y      (sp_y),
    .span_length (sp_len),
    .span_color  (sp_color),
    .span_last   (out_tlast)
  );

  assign out_tdata = OUT_W'({sp_color, sp_len, sp_y, sp_x});

endmodule

// ----- verif/row_span_checker.sv -----
`timescale 1ns / 1ps

module row_span_checker
  import rers_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          spans_left
);

  localparam int CB           = COORD_BITS_DEF;
  localparam int SB           = CB + 1;
  localparam int O_Y          = CB;
  localparam int O_W          = 2 * CB;
  localparam int O_H          = O_W + SB;
  localparam int O_RAD        = O_H + SB;
  localparam int O_FILL       = O_RAD + CB;
  localparam int O_HI         = O_FILL + COLOR_BITS;
  localparam int O_SH         = O_HI + COLOR_BITS;
  localparam int O_ROW        = O_SH + COLOR_BITS;
  localparam int ROOT_ARG_CAP = 46340;

  typedef struct {
    logic [SB-1:0]         sx;
    logic [SB-1:0]         sy;
    logic [SB-1:0]         slen;
    logic [COLOR_BITS-1:0] scolor;
    logic                  slast;
  } span_t;

  span_t spans_due[$];

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned acc, t;
    int b;
    if (v > ROOT_ARG_CAP) v = ROOT_ARG_CAP;
    acc = 0;
    for (b = 7; b >= 0; b--) begin
      t = acc | (32'd1 << b);
      if (t * t <= v) acc = t;
    end
    return acc;
  endfunction

  function automatic void queue_span(input int unsigned px, py, plen, pcolor);
    span_t s;
    if (plen == 0) return;
    s.sx     = px[SB-1:0];
    s.sy     = py[SB-1:0];
    s.slen   = plen[SB-1:0];
    s.scolor = pcolor[COLOR_BITS-1:0];
    s.slast  = 1'b0;
    spans_due.push_back(s);
  endfunction

  // spans of one row, in paint order
  function automatic void predict_row_spans(input logic [95:0] d, input logic outline);
    int unsigned x, y, w, h, r, fill, hi, sh, yo, sy, dx, dy, inner;
    bit arc;
    int first;
    first = spans_due.size();
    x    = 32'(d[0 +: CB]);
    y    = 32'(d[O_Y +: CB]);
    w    = 32'(d[O_W +: SB]);
    h    = 32'(d[O_H +: SB]);
    r    = 32'(d[O_RAD +: CB]);
    fill = 32'(d[O_FILL +: COLOR_BITS]);
    hi   = 32'(d[O_HI +: COLOR_BITS]);
    sh   = 32'(d[O_SH +: COLOR_BITS]);
    yo   = 32'(d[O_ROW +: CB]);
    if (yo >= h) return;
    if (r > w / 2) r = w / 2;
    if (r > h / 2) r = h / 2;
    sy    = y + yo;
    inner = w - 2 * r;
    arc   = 1'b0;
    dx    = 0;
    if (yo < r) begin
      dy  = r - yo;
      arc = 1'b1;
      dx  = floor_root(r * r - dy * dy);
    end else if (yo >= h - r) begin
      dy  = yo - (h - r);
      arc = 1'b1;
      dx  = floor_root(r * r - dy * dy);
    end
    if (!outline) begin
      if (arc) queue_span(x + r, sy, inner, fill);
      else queue_span(x, sy, w, fill);
      if (arc && dx > 0) begin
        queue_span(x + r - dx, sy, dx, fill);
        queue_span(x + w - r, sy, dx, fill);
      end
    end
    if (yo == 0 && w > 2 * r) queue_span(x + r, sy, inner, hi);
    if (arc) queue_span(x + r - dx, sy, 1, hi);
    if (yo == h - 1 && w > 2 * r) queue_span(x + r, sy, inner, sh);
    if (arc) queue_span(x + w - 1 - r + dx, sy, 1, sh);
    if (spans_due.size() > first) spans_due[spans_due.size() - 1].slast = 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    spans_left = 0;
  end

  always @(posedge clk) begin : watch
    span_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (spans_due.size() == 0) begin
          $error("span item with none pending: tdata=%h tlast=%b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          e = spans_due.pop_front();
          if (out_tdata[0 +: SB] !== e.sx) begin
            $error("span_x: expected %0d, got %0d", e.sx, out_tdata[0 +: SB]);
            fail_count++;
          end
          if (out_tdata[SB +: SB] !== e.sy) begin
            $error("span_y: expected %0d, got %0d", e.sy, out_tdata[SB +: SB]);
            fail_count++;
          end
          if (out_tdata[2*SB +: SB] !== e.slen) begin
            $error("span_length: expected %0d, got %0d", e.slen, out_tdata[2*SB +: SB]);
            fail_count++;
          end
          if (out_tdata[3*SB +: COLOR_BITS] !== e.scolor) begin
            $error("color: expected %0d, got %0d", e.scolor,
                   out_tdata[3*SB +: COLOR_BITS]);
            fail_count++;
          end
          if (out_tlast !== e.slast) begin
            $error("last: expected %0d, got %0d", e.slast, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_row_spans(in_tdata, in_tuser[0]);
    end
    spans_left = spans_due.size();
  end

endmodule

// ----- verif/rounded_emboss_row_spans_tb.sv -----
`timescale 1ns / 1ps

module rounded_emboss_row_spans_tb;
  import rers_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int SB         = CB + 1;
  localparam int IN_BITS    = 4 * CB + 2 * SB + 3 * COLOR_BITS;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((3 * SB + COLOR_BITS + 7) / 8) * 8;
  localparam int N_RANDOM   = 480;
  localparam int STALL_MAX  = 4000;
  localparam int DRAIN      = 40;
  localparam int HOLD_AFTER = 250;
  localparam int HOLD_LEN   = 300;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic [0:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  int               check_fails;
  int               spans_left;

  rounded_emboss_row_spans uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  row_span_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .fail_count(check_fails),
    .spans_left(spans_left)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_row(input logic c, input logic [CB-1:0] x, y,
                          input logic [SB-1:0] w, h, input logic [CB-1:0] r,
                          input logic [7:0] f, hi, sh, input logic [CB-1:0] yo);
    @(negedge clk);
    in_tuser  <= c;
    in_tdata  <= IN_W'({yo, sh, hi, f, r, h, w, y, x});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'({$urandom, $urandom, $urandom});
      in_tuser  <= 1'($urandom);
    end
  endtask

  function automatic logic [SB-1:0] pick_extent();
    case ($urandom_range(0, 19))
      0:       return SB'($urandom_range(0, 4095));
      1, 2, 3: return SB'($urandom_range(1, 2048));
      default: return SB'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_radius(input int unsigned w, h);
    int unsigned m;
    m = (w < h) ? w : h;
    case ($urandom_range(0, 9))
      0, 1, 2: return 0;
      3, 4:    return CB'($urandom_range(0, 2047));
      default: return CB'($urandom_range(0, m / 2 + 2));
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_row(input int unsigned h, r);
    int unsigned top, span;
    if (h == 0) return CB'($urandom_range(0, 2047));
    top  = (h - 1 > 2047) ? 2047 : h - 1;
    span = (r + 1 > top) ? top : r + 1;
    case ($urandom_range(0, 7))
      0:       return CB'($urandom_range(0, 2047));
      1:       return 0;
      2:       return CB'(top);
      3:       return CB'($urandom_range(0, span));
      4:       return CB'($urandom_range(top - span, top));
      default: return CB'($urandom_range(0, top));
    endcase
  endfunction

  // receiver: mixed ready pattern, one long hold-off early on
  initial begin : ready_pattern
    int seen, seg, mode;
    bit held;
    out_tready = 1'b0;
    held       = 1'b0;
    seen       = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && seen >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_LEN) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        seg  = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(1, 40);
        repeat (seg) begin
          @(negedge clk);
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom);
            2:       out_tready <= 1'b0;
            default: out_tready <= seen[0];
          endcase
          seen++;
        end
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stalled = 0;
      else stalled++;
    end
    $display("[rounded_emboss_row_spans] ERROR");
    $finish;
  end

  initial begin : stimulus
    int k, burst_left;
    logic [SB-1:0] w, h;
    logic [CB-1:0] r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // typical rectangle: top row, arc row, bottom row (six spans), middle, outline rows, outside
    send_row(0, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 0);
    send_row(0, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 1);
    send_row(0, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 29);
    send_row(0, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 15);
    send_row(1, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 0);
    send_row(1, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 4);
    send_row(1, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 15);
    send_row(1, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 29);
    send_row(0, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 30);
    send_row(0, 100, 40, 60, 30, 8, 8'h11, 8'h22, 8'h33, 2047);
    // zero width / height
    send_row(0, 10, 10, 0, 20, 5, 8'h44, 8'h55, 8'h66, 3);
    send_row(0, 10, 10, 20, 0, 5, 8'h44, 8'h55, 8'h66, 0);
    // square corners, single pixel
    send_row(0, 7, 9, 25, 10, 0, 8'h01, 8'h02, 8'h03, 0);
    send_row(0, 7, 9, 25, 10, 0, 8'h01, 8'h02, 8'h03, 9);
    send_row(0, 0, 0, 1, 1, 0, 8'h00, 8'hFF, 8'h80, 0);
    // radius clamped to half width, odd and even widths
    send_row(0, 50, 60, 5, 20, 9, 8'hA5, 8'h5A, 8'hC3, 0);
    send_row(0, 50, 60, 5, 20, 9, 8'hA5, 8'h5A, 8'hC3, 19);
    send_row(0, 50, 60, 16, 16, 8, 8'hA5, 8'h5A, 8'hC3, 0);
    send_row(0, 50, 60, 16, 16, 8, 8'hA5, 8'h5A, 8'hC3, 8);
    send_row(0, 50, 60, 16, 16, 8, 8'hA5, 8'h5A, 8'hC3, 15);
    // large radius, saturated inset
    send_row(0, 0, 0, 2048, 2048, 1024, 8'h00, 8'hFF, 8'h00, 0);
    send_row(0, 0, 0, 2048, 2048, 1024, 8'hFF, 8'h00, 8'hFF, 1);
    send_row(0, 0, 0, 2048, 2048, 1024, 8'h00, 8'hFF, 8'h00, 1000);
    send_row(1, 0, 0, 2048, 2048, 1024, 8'hFF, 8'h00, 8'hFF, 2047);
    // all fields at maximum, coordinates wrap
    send_row(0, 2047, 2047, 4095, 4095, 2047, 8'hFF, 8'hFF, 8'hFF, 2047);

    burst_left = 0;
    for (k = 0; k < N_RANDOM; k++) begin
      if (burst_left == 0) begin
        idle_gap(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      w = pick_extent();
      h = pick_extent();
      r = pick_radius(32'(w), 32'(h));
      send_row(($urandom_range(0, 3) == 0), CB'($urandom_range(0, 2047)),
               CB'($urandom_range(0, 2047)), w, h, r, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               pick_row(32'(h), 32'(r)));
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (spans_left == 0);
    repeat (DRAIN) @(posedge clk);
    if (check_fails == 0 && spans_left == 0) begin
      $display("[rounded_emboss_row_spans] OK");
    end else begin
      $display("[rounded_emboss_row_spans] ERROR");
    end
    $finish;
  end

endmodule
